// ===== rtl/scr_pkg.sv =====
package scr_pkg;

    // field widths
    localparam int ENERGY_W = 16;
    localparam int COORD_W  = 16;
    localparam int FRAC_W   = 16;
    localparam int R2_W     = 34;
    localparam int RAD_W    = 17;
    localparam int STAT_W   = 2;

    // default store depth
    localparam int DEF_MAX_HITS = 1024;

    // register reset values
    localparam logic [FRAC_W-1:0] FRAC_RESET = 16'd62259;

    // register indexes
    localparam logic REG_FRAC = 1'b0;
    localparam logic REG_SKIP = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [ENERGY_W-1:0]       energy;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic                      is_masked;
        logic                      last_hit;
    } hit_t;

    typedef struct packed {
        logic [RAD_W-1:0]  radius;
        logic [STAT_W-1:0] status;
    } result_t;

endpackage

// ===== rtl/scr_div.sv =====
module scr_div #(
    parameter int DVD_W = 42,
    parameter int DVS_W = 26
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0]        divisor,
    output logic                    done,
    output logic signed [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] sh_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   trial;
    logic             ge;
    logic [DVS_W:0]   diff;

    // one restoring step a cycle, quotient bits shift in behind the dividend
    assign trial = {rem_reg, sh_reg[DVD_W-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[DVD_W-1];
            sh_reg  <= dividend[DVD_W-1] ? (~dividend + 1'b1) : dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            sh_reg  <= {sh_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? $signed(~sh_reg + 1'b1) : $signed(sh_reg);

endmodule

// ===== rtl/scr_isqrt.sv =====
module scr_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [scr_pkg::R2_W-1:0]   value,
    output logic                       done,
    output logic [scr_pkg::RAD_W-1:0]  root
);

    localparam int VW    = scr_pkg::R2_W;
    localparam int RW    = scr_pkg::RAD_W;
    localparam int CNT_W = $clog2(RW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [VW-1:0]    val_reg;
    logic [RW+1:0]    rem_reg;
    logic [RW-1:0]    root_reg;

    logic [RW+3:0]    rem_sh;
    logic [RW+3:0]    trial;
    logic             ge;
    logic [RW+3:0]    diff;

    // two bits of the operand per cycle
    assign rem_sh = {rem_reg, val_reg[VW-1:VW-2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign ge     = (rem_sh >= trial);
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(RW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg  <= {val_reg[VW-3:0], 2'b00};
            rem_reg  <= ge ? diff[RW+1:0] : rem_sh[RW+1:0];
            root_reg <= {root_reg[RW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== rtl/shower_containment_radius_unit.sv =====
// Energy containment radius of one event. While loading, hits enter one per
// cycle and are written to the hit memory while the energy total and the
// energy-weighted x and y sums build up, except masked hits when skipping is
// set and hits beyond the memory depth; hit_stall stays low throughout loading.
// The hit that carries last_hit starts the evaluation, during which hit_stall
// is high: two serial divisions for the barycenter, one pass over the n stored
// hits that writes each squared radius into a second memory, then a bisection
// over the squared radius of at most 35 steps, each a pass over both memories
// at one read a cycle, and a square root. An event with no usable energy or
// with dropped hits skips these steps and reports an empty or overflow status.
// The result waits in an output register, and loading of the next event
// continues while it is not taken.
module shower_containment_radius_unit #(
    parameter int MAX_HITS = scr_pkg::DEF_MAX_HITS
) (
    input  logic            clk,
    input  logic            rst_n,
    // hit channel
    input  logic            hit_valid,
    output logic            hit_stall,
    input  scr_pkg::hit_t   hit,
    // result channel
    output logic            res_valid,
    input  logic            res_stall,
    output scr_pkg::result_t res,
    // register port
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    localparam int AW     = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
    localparam int CW     = $clog2(MAX_HITS + 1);
    localparam int EW     = scr_pkg::ENERGY_W;
    localparam int XW     = scr_pkg::COORD_W;
    localparam int ET_W   = EW + AW;
    localparam int MOM_W  = 2 * XW + AW;
    localparam int GOAL_W = scr_pkg::FRAC_W + ET_W;
    localparam int R2W    = scr_pkg::R2_W;
    localparam int SQ_W   = R2W - 1;
    localparam int HW     = EW + 2 * XW;

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_DIVX  = 4'd2;
    localparam logic [3:0] S_DIVY  = 4'd3;
    localparam logic [3:0] S_R2    = 4'd4;
    localparam logic [3:0] S_SRCH  = 4'd5;
    localparam logic [3:0] S_SCAN  = 4'd6;
    localparam logic [3:0] S_SQRT  = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    // control state
    logic [3:0]                   state_reg;
    logic [scr_pkg::FRAC_W-1:0]   frac_reg;
    logic                         skip_reg;
    logic [CW-1:0]                count_reg;
    logic [ET_W-1:0]              total_reg;
    logic signed [MOM_W-1:0]      xmom_reg;
    logic signed [MOM_W-1:0]      ymom_reg;
    logic                         ovf_reg;
    logic                         res_valid_reg;
    scr_pkg::result_t             res_reg;
    scr_pkg::result_t             stage_reg;

    // evaluation datapath
    logic signed [XW-1:0]         bx_reg;
    logic signed [XW-1:0]         by_reg;
    logic [GOAL_W-1:0]            goal_reg;
    logic [R2W-1:0]               max_reg;
    logic [R2W-1:0]               lo_reg;
    logic [R2W-1:0]               hi_reg;
    logic [R2W-1:0]               mid_reg;
    logic [ET_W-1:0]              cum_reg;
    logic                         any_reg;

    // scan sequencer
    logic                         scan_on_reg;
    logic [CW-1:0]                scan_addr_reg;
    logic                         v1_reg;
    logic                         v2_reg;
    logic                         v3_reg;
    logic [AW-1:0]                a1_reg;
    logic [AW-1:0]                a2_reg;
    logic [AW-1:0]                a3_reg;
    logic signed [XW:0]           dx_reg;
    logic signed [XW:0]           dy_reg;
    logic [SQ_W-1:0]              dxsq_reg;
    logic [SQ_W-1:0]              dysq_reg;

    // memories
    logic [HW-1:0]                hit_mem [MAX_HITS];
    logic [R2W-1:0]               r2_mem  [MAX_HITS];
    logic [HW-1:0]                hit_rd_reg;
    logic [R2W-1:0]               r2_rd_reg;

    logic                         hit_acc;
    logic                         hit_use;
    logic                         room;
    logic                         hit_we;
    logic                         cfg_we;
    logic                         res_free;
    logic                         emit;
    logic                         scan_idle;
    logic [R2W-1:0]               r2_sum;
    logic [R2W:0]                 mid_sum;
    logic                         pass_ok;
    logic signed [2*XW:0]         xe_prod;
    logic signed [2*XW:0]         ye_prod;
    logic signed [2*XW+1:0]       dxsq_full;
    logic signed [2*XW+1:0]       dysq_full;
    logic [EW-1:0]                rd_energy;
    logic signed [XW-1:0]         rd_x;
    logic signed [XW-1:0]         rd_y;

    logic                         div_start;
    logic signed [MOM_W-1:0]      div_dvd;
    logic                         div_done;
    logic signed [MOM_W-1:0]      div_q;
    logic                         sq_start;
    logic                         sq_done;
    logic [scr_pkg::RAD_W-1:0]    sq_root;

    // handshake terms
    assign hit_stall = (state_reg != S_LOAD);
    assign hit_acc   = hit_valid & ~hit_stall;
    assign hit_use   = ~(skip_reg & hit.is_masked);
    assign room      = (count_reg < CW'(MAX_HITS));
    assign hit_we    = hit_acc & hit_use & room;
    assign res_free  = ~res_valid_reg | ~res_stall;
    assign emit      = (state_reg == S_EMIT) & res_free;
    assign cfg_we    = psel & penable & pwrite;
    assign scan_idle = ~scan_on_reg & ~v1_reg & ~v2_reg & ~v3_reg;

    // moment products of the incoming hit
    assign xe_prod = hit.pos_x * $signed({1'b0, hit.energy});
    assign ye_prod = hit.pos_y * $signed({1'b0, hit.energy});

    // memory read fields
    assign rd_energy = hit_rd_reg[HW-1 -: EW];
    assign rd_x      = $signed(hit_rd_reg[2*XW-1 -: XW]);
    assign rd_y      = $signed(hit_rd_reg[XW-1:0]);

    // squared distance terms
    assign dxsq_full = dx_reg * dx_reg;
    assign dysq_full = dy_reg * dy_reg;
    assign r2_sum    = {1'b0, dxsq_reg} + {1'b0, dysq_reg};

    // bisection decision at the end of a pass
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign pass_ok = any_reg && ({cum_reg, {scr_pkg::FRAC_W{1'b0}}} >= goal_reg);

    // shared units
    assign div_start = ((state_reg == S_CHECK) && (count_reg != '0) && (total_reg != '0)
                        && !ovf_reg) || ((state_reg == S_DIVX) && div_done);
    assign div_dvd   = (state_reg == S_DIVX) ? ymom_reg : xmom_reg;
    assign sq_start  = (state_reg == S_SRCH) && (lo_reg == hi_reg);

    scr_div #(
        .DVD_W (MOM_W),
        .DVS_W (ET_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    scr_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (lo_reg),
        .done  (sq_done),
        .root  (sq_root)
    );

    // hit memory: written while loading, read by the scan sequencer
    always_ff @(posedge clk)
    begin
        if (hit_we)
            hit_mem[count_reg[AW-1:0]] <= {hit.energy, hit.pos_x, hit.pos_y};
        hit_rd_reg <= hit_mem[scan_addr_reg[AW-1:0]];
    end

    // squared radius memory: written in the radius pass, read in the bisection
    // passes which start only after that pass has drained
    always_ff @(posedge clk)
    begin
        if (v3_reg && (state_reg == S_R2))
            r2_mem[a3_reg] <= r2_sum;
        r2_rd_reg <= r2_mem[scan_addr_reg[AW-1:0]];
    end

    // scan pipeline payload
    always_ff @(posedge clk)
    begin
        a1_reg   <= scan_addr_reg[AW-1:0];
        a2_reg   <= a1_reg;
        a3_reg   <= a2_reg;
        dx_reg   <= {rd_x[XW-1], rd_x} - {bx_reg[XW-1], bx_reg};
        dy_reg   <= {rd_y[XW-1], rd_y} - {by_reg[XW-1], by_reg};
        dxsq_reg <= dxsq_full[SQ_W-1:0];
        dysq_reg <= dysq_full[SQ_W-1:0];
    end

    // register port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_reg <= scr_pkg::FRAC_RESET;
            skip_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (paddr[2])
                scr_pkg::REG_FRAC: frac_reg <= pwdata[scr_pkg::FRAC_W-1:0];
                scr_pkg::REG_SKIP: skip_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    assign prdata = (paddr[2] == scr_pkg::REG_SKIP) ? {31'd0, skip_reg}
                                                    : {16'd0, frac_reg};
    assign pready = 1'b1;

    // result register, loaded only when the previous transaction is gone
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else if (emit)
        begin
            res_valid_reg <= 1'b1;
            res_reg       <= stage_reg;
        end
        else if (res_valid_reg && !res_stall)
            res_valid_reg <= 1'b0;
    end

    // sequencer and event sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            total_reg     <= '0;
            xmom_reg      <= '0;
            ymom_reg      <= '0;
            ovf_reg       <= 1'b0;
            stage_reg     <= '0;
            scan_on_reg   <= 1'b0;
            scan_addr_reg <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            bx_reg        <= '0;
            by_reg        <= '0;
            goal_reg      <= '0;
            max_reg       <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            mid_reg       <= '0;
            cum_reg       <= '0;
            any_reg       <= 1'b0;
        end
        else
        begin
            // scan address issue and valid pipeline
            v1_reg <= scan_on_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (scan_on_reg)
            begin
                scan_addr_reg <= scan_addr_reg + 1'b1;
                if (scan_addr_reg == count_reg - 1'b1)
                    scan_on_reg <= 1'b0;
            end

            unique case (state_reg)
                S_LOAD:
                begin
                    if (hit_acc)
                    begin
                        if (hit_use)
                        begin
                            if (room)
                            begin
                                count_reg <= count_reg + 1'b1;
                                total_reg <= total_reg + ET_W'(hit.energy);
                                xmom_reg  <= xmom_reg + MOM_W'(xe_prod);
                                ymom_reg  <= ymom_reg + MOM_W'(ye_prod);
                            end
                            else
                                ovf_reg <= 1'b1;
                        end
                        if (hit.last_hit)
                            state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if ((count_reg == '0) || (total_reg == '0))
                    begin
                        stage_reg <= '{radius: '0, status: scr_pkg::ST_EMPTY};
                        state_reg <= S_EMIT;
                    end
                    else if (ovf_reg)
                    begin
                        stage_reg <= '{radius: '0, status: scr_pkg::ST_OVERFLOW};
                        state_reg <= S_EMIT;
                    end
                    else
                        state_reg <= S_DIVX;
                end
                S_DIVX:
                begin
                    if (div_done)
                    begin
                        bx_reg    <= div_q[XW-1:0];
                        state_reg <= S_DIVY;
                    end
                end
                S_DIVY:
                begin
                    if (div_done)
                    begin
                        by_reg        <= div_q[XW-1:0];
                        goal_reg      <= frac_reg * total_reg;
                        max_reg       <= '0;
                        scan_addr_reg <= '0;
                        scan_on_reg   <= 1'b1;
                        state_reg     <= S_R2;
                    end
                end
                S_R2:
                begin
                    if (v3_reg && (r2_sum > max_reg))
                        max_reg <= r2_sum;
                    if (scan_idle)
                    begin
                        lo_reg    <= '0;
                        hi_reg    <= max_reg;
                        state_reg <= S_SRCH;
                    end
                end
                S_SRCH:
                begin
                    if (lo_reg == hi_reg)
                        state_reg <= S_SQRT;
                    else
                    begin
                        mid_reg       <= mid_sum[R2W:1];
                        cum_reg       <= '0;
                        any_reg       <= 1'b0;
                        scan_addr_reg <= '0;
                        scan_on_reg   <= 1'b1;
                        state_reg     <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // energy of hits at or inside the trial radius
                    if (v1_reg && (r2_rd_reg <= mid_reg))
                    begin
                        cum_reg <= cum_reg + ET_W'(rd_energy);
                        any_reg <= 1'b1;
                    end
                    if (scan_idle)
                    begin
                        if (pass_ok)
                            hi_reg <= mid_reg;
                        else
                            lo_reg <= mid_reg + 1'b1;
                        state_reg <= S_SRCH;
                    end
                end
                S_SQRT:
                begin
                    if (sq_done)
                    begin
                        stage_reg <= '{radius: sq_root, status: scr_pkg::ST_OK};
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (res_free)
                    begin
                        count_reg     <= '0;
                        total_reg     <= '0;
                        xmom_reg      <= '0;
                        ymom_reg      <= '0;
                        ovf_reg       <= 1'b0;
                        state_reg     <= S_LOAD;
                    end
                end
                default:
                    state_reg <= S_LOAD;
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_HITS))
        else $error("stored hit count beyond store depth");

    a_status_radius: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_reg.status == scr_pkg::ST_OK) || (res_reg.radius == '0))
        else $error("nonzero radius with error status");

    a_bisect_order: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SRCH) || (state_reg == S_SCAN)) |-> (lo_reg <= hi_reg))
        else $error("bisection bounds crossed");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIVX) || (state_reg == S_DIVY))
        else $error("divider finished outside barycenter phase");

    a_load_only_stall: assert property (@(posedge clk) disable iff (!rst_n)
        hit_acc && hit.last_hit |=> hit_stall)
        else $error("hit taken during evaluation");

endmodule
